[rtl/slcd_pkg.sv]
`default_nettype none

package slcd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] COMMAND_HIGHEST_RST = 8'hff;
	localparam logic [BYTE_W-1:0] COMMAND_ALWAYS_OK   = 8'h01;
	localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST    = 16'h6000;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_ACCEPT   = 2'd1,
		KIND_CSUM_ERR = 2'd2,
		KIND_LEN_DROP = 2'd3
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SYNC_FIRST      = 3'd0,
		REG_SYNC_SECOND     = 3'd1,
		REG_SYNC_THIRD      = 3'd2,
		REG_COMMAND_LOWEST  = 3'd3,
		REG_COMMAND_HIGHEST = 3'd4,
		REG_LENGTH_LIMIT    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [BYTE_W-1:0] sync_third;
		logic [BYTE_W-1:0] command_lowest;
		logic [BYTE_W-1:0] command_highest;
		logic [LEN_W-1:0]  length_limit;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] module_id;
		logic [BYTE_W-1:0] command_code;
		logic [LEN_W-1:0]  payload_length;
	} result_t;

endpackage

`default_nettype wire

[rtl/slcd_if.sv]
`default_nettype none

interface slcd_byte_if;
	logic                         valid;
	logic                         ready;
	logic [slcd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_result_if;
	logic                         valid;
	logic                         ready;
	slcd_pkg::kind_t              kind;
	logic [slcd_pkg::BYTE_W-1:0]  payload_byte;
	logic [slcd_pkg::BYTE_W-1:0]  module_id;
	logic [slcd_pkg::BYTE_W-1:0]  command_code;
	logic [slcd_pkg::LEN_W-1:0]   payload_length;

	modport source (output valid, output kind, output payload_byte, output module_id,
		output command_code, output payload_length, input ready);
	modport sink   (input valid, input kind, input payload_byte, input module_id,
		input command_code, input payload_length, output ready);
endinterface

interface slcd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [slcd_pkg::REG_IDX_W-1:0]  reg_index;
	logic [slcd_pkg::LEN_W-1:0]      wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/slcd_cfg.sv]
`default_nettype none

module slcd_cfg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	slcd_cfg_if.sink             cfg,
	output slcd_pkg::cfg_t       cfg_regs
);
	import slcd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_first      <= '0;
			regs_q.sync_second     <= '0;
			regs_q.sync_third      <= '0;
			regs_q.command_lowest  <= '0;
			regs_q.command_highest <= COMMAND_HIGHEST_RST;
			regs_q.length_limit    <= LENGTH_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			// indexes past the list are dropped
			unique case (cfg.reg_index)
				REG_SYNC_FIRST:      regs_q.sync_first      <= cfg.wdata[BYTE_W-1:0];
				REG_SYNC_SECOND:     regs_q.sync_second     <= cfg.wdata[BYTE_W-1:0];
				REG_SYNC_THIRD:      regs_q.sync_third      <= cfg.wdata[BYTE_W-1:0];
				REG_COMMAND_LOWEST:  regs_q.command_lowest  <= cfg.wdata[BYTE_W-1:0];
				REG_COMMAND_HIGHEST: regs_q.command_highest <= cfg.wdata[BYTE_W-1:0];
				REG_LENGTH_LIMIT:    regs_q.length_limit    <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/slcd_core.sv]
`default_nettype none

module slcd_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [slcd_pkg::BYTE_W-1:0] rx_byte,
	input  wire slcd_pkg::cfg_t              cfg_regs,
	output logic                             emit,
	output slcd_pkg::result_t                res
);
	import slcd_pkg::*;

	typedef enum logic [8:0] {
		ST_HUNT     = 9'b000000001,
		ST_SYNC1    = 9'b000000010,
		ST_SYNC2    = 9'b000000100,
		ST_MODULE   = 9'b000001000,
		ST_COMMAND  = 9'b000010000,
		ST_LEN_HI   = 9'b000100000,
		ST_LEN_LO   = 9'b001000000,
		ST_PAYLOAD  = 9'b010000000,
		ST_CHECKSUM = 9'b100000000
	} state_t;

	state_t            state_q, state_d, hunt_next;
	logic [BYTE_W-1:0] sum_q, sum_d, sum_add;
	logic [BYTE_W-1:0] module_q, module_d;
	logic [BYTE_W-1:0] command_q, command_d;
	logic [LEN_W-1:0]  length_q, length_d;
	logic [LEN_W-1:0]  remain_q, remain_d;
	logic              restart;
	logic              cmd_reject;

	assign hunt_next  = (rx_byte == cfg_regs.sync_first) ? ST_SYNC1 : ST_HUNT;
	assign sum_add    = sum_q + rx_byte;
	assign cmd_reject = (rx_byte < cfg_regs.command_lowest ||
		rx_byte > cfg_regs.command_highest) && rx_byte != COMMAND_ALWAYS_OK;

	always_comb begin
		state_d          = state_q;
		sum_d            = sum_q;
		module_d         = module_q;
		command_d        = command_q;
		length_d         = length_q;
		remain_d         = remain_q;
		restart          = 1'b0;
		emit             = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = '0;
		unique case (state_q) inside
			ST_HUNT: begin
				state_d = hunt_next;
			end
			ST_SYNC1: begin
				if (rx_byte == cfg_regs.sync_second) begin
					state_d = ST_SYNC2;
				end else begin
					restart = 1'b1;
					state_d = hunt_next;
				end
			end
			ST_SYNC2: begin
				if (rx_byte == cfg_regs.sync_third) begin
					state_d = ST_MODULE;
				end else begin
					restart = 1'b1;
					state_d = hunt_next;
				end
			end
			ST_MODULE: begin
				module_d = rx_byte;
				sum_d    = rx_byte;
				state_d  = ST_COMMAND;
			end
			ST_COMMAND: begin
				if (cmd_reject) begin
					restart = 1'b1;
					state_d = hunt_next;
				end else begin
					command_d = rx_byte;
					sum_d     = sum_add;
					state_d   = ST_LEN_HI;
				end
			end
			ST_LEN_HI, ST_LEN_LO: begin
				if (state_q == ST_LEN_HI) begin
					length_d = {rx_byte, {BYTE_W{1'b0}}};
				end else begin
					length_d = {length_q[LEN_W-1:BYTE_W], rx_byte};
				end
				sum_d = sum_add;
				if (length_d > cfg_regs.length_limit) begin
					emit     = 1'b1;
					res.kind = KIND_LEN_DROP;
					restart  = 1'b1;
					state_d  = ST_HUNT;
				end else if (state_q == ST_LEN_HI) begin
					state_d = ST_LEN_LO;
				end else begin
					remain_d = length_d;
					state_d  = (length_d == '0) ? ST_CHECKSUM : ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				emit             = 1'b1;
				res.payload_byte = rx_byte;
				sum_d            = sum_add;
				remain_d         = remain_q - LEN_W'(1);
				if (remain_q == {{(LEN_W-1){1'b0}}, 1'b1}) begin
					state_d = ST_CHECKSUM;
				end
			end
			ST_CHECKSUM: begin
				emit     = 1'b1;
				res.kind = (sum_q == rx_byte) ? KIND_ACCEPT : KIND_CSUM_ERR;
				restart  = 1'b1;
				state_d  = ST_HUNT;
			end
			default: begin
				restart = 1'b1;
				state_d = ST_HUNT;
			end
		endcase
		res.module_id      = module_d;
		res.command_code   = command_d;
		res.payload_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HUNT;
			sum_q     <= '0;
			module_q  <= '0;
			command_q <= '0;
			length_q  <= '0;
			remain_q  <= '0;
		end else if (step) begin
			state_q  <= state_d;
			remain_q <= remain_d;
			if (restart) begin
				sum_q     <= '0;
				module_q  <= '0;
				command_q <= '0;
				length_q  <= '0;
			end else begin
				sum_q     <= sum_d;
				module_q  <= module_d;
				command_q <= command_d;
				length_q  <= length_d;
			end
		end
	end

	a_payload_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAYLOAD |-> remain_q != '0)
		else $error("payload state with no bytes left");

	a_payload_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind == KIND_PAYLOAD |-> state_q == ST_PAYLOAD)
		else $error("payload word outside payload state");

	a_drop_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind == KIND_LEN_DROP |-> state_q == ST_LEN_HI || state_q == ST_LEN_LO)
		else $error("length drop outside length bytes");

endmodule

`default_nettype wire

[rtl/sync_length_checksum_deframer.sv]
`default_nettype none

// Channel     Dir  Payload                                               Notes
// byte_in     in   rx_byte[7:0]                                          one received byte
// result_out  out  kind[1:0] payload_byte module_id command_code
//                  payload_length[15:0]                                  zero or one per byte
// cfg         in   reg_index[2:0] wdata[15:0]                            always ready
//
// One byte is taken per cycle while result_out does not stall; it waits in the
// input register until it advances into the frame tracker, and its result, if
// any, is loaded into the result register on that advance and leaves from there.
// The frame tracker in slcd_core updates all of its state on each advance, so
// it takes one byte per clock unless a stall on result_out holds it.
// arst_n clears the pipeline valids, the frame state and the config registers.
// A stall on result_out holds the result register; byte_in stays ready while
// the result register drains in the same cycle.
module sync_length_checksum_deframer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	slcd_byte_if.sink     byte_in,
	slcd_result_if.source result_out,
	slcd_cfg_if.sink      cfg
);
	import slcd_pkg::*;

	cfg_t              cfg_regs;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           core_res;
	logic              core_emit;
	logic              s2_free;
	logic              advance;

	slcd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	// Advance the input word into the frame tracker when the result slot can
	// take whatever it produces.
	assign s2_free       = !valid_s2 || result_out.ready;
	assign advance       = valid_s1 && s2_free;
	assign byte_in.ready = !valid_s1 || s2_free;

	slcd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.rx_byte  (byte_s1),
		.cfg_regs (cfg_regs),
		.emit     (core_emit),
		.res      (core_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.rx_byte;
		end
	end

	// Result register: load on advance (a byte with no result leaves it
	// empty), otherwise drop the word once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= core_emit;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_emit) begin
			res_s2 <= core_res;
		end
	end

	assign result_out.valid          = valid_s2;
	assign result_out.kind           = res_s2.kind;
	assign result_out.payload_byte   = res_s2.payload_byte;
	assign result_out.module_id      = res_s2.module_id;
	assign result_out.command_code   = res_s2.command_code;
	assign result_out.payload_length = res_s2.payload_length;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(byte_s1))
		else $error("input word lost while result slot was full");

	a_load_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 == $past(core_emit))
		else $error("result slot out of step with frame tracker");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind != KIND_PAYLOAD |-> res_s2.payload_byte == '0)
		else $error("nonzero payload byte on a frame status word");

endmodule

`default_nettype wire

[sim/sync_length_checksum_deframer_test.sv]
`default_nettype none

module sync_length_checksum_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slcd_pkg::*;

	// Byte positions inside a frame, counted from the first sync byte.
	localparam logic [16:0] POS_HUNT    = 17'd0;
	localparam logic [16:0] POS_SYNC2   = 17'd1;
	localparam logic [16:0] POS_SYNC3   = 17'd2;
	localparam logic [16:0] POS_MODULE  = 17'd3;
	localparam logic [16:0] POS_COMMAND = 17'd4;
	localparam logic [16:0] POS_LEN_HI  = 17'd5;
	localparam logic [16:0] POS_LEN_LO  = 17'd6;
	localparam logic [16:0] POS_PAYLOAD = 17'd7;

	// Covers the input register and the result register, with a margin on top.
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASE_BYTES   = 330;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	slcd_byte_if   byte_ch();
	slcd_result_if result_ch();
	slcd_cfg_if    cfg_ch();

	sync_length_checksum_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (result_ch),
		.cfg        (cfg_ch)
	);

	always #5 clk = ~clk;

	// Shadow of the register file, as the block should hold it.
	cfg_t shadow_cfg = '{8'h00, 8'h00, 8'h00, 8'h00, COMMAND_HIGHEST_RST, LENGTH_LIMIT_RST};

	// Frame tracker state of the deframer prediction.
	logic [16:0] frame_pos     = POS_HUNT;
	logic [7:0]  frame_sum     = '0;
	logic [7:0]  frame_module  = '0;
	logic [7:0]  frame_command = '0;
	logic [15:0] frame_length  = '0;

	result_t expected_results [$];

	int send_idle_pct  = 24;
	int recv_stall_pct = 87;
	int bytes_sent     = 0;
	int settings_done  = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;
	int kind_count [4] = '{0, 0, 0, 0};

	// ---------------------------------------------------------------
	// Deframer prediction
	// ---------------------------------------------------------------

	function automatic void restart_hunt();
		frame_pos     = POS_HUNT;
		frame_sum     = '0;
		frame_module  = '0;
		frame_command = '0;
		frame_length  = '0;
	endfunction

	// Drop the frame and try this byte as the first sync byte.
	function automatic void hunt_from(input logic [7:0] b);
		restart_hunt();
		if (b == shadow_cfg.sync_first)
			frame_pos = POS_SYNC2;
	endfunction

	function automatic result_t frame_result(input kind_t k, input logic [7:0] pay);
		result_t r;
		r.kind           = k;
		r.payload_byte   = pay;
		r.module_id      = frame_module;
		r.command_code   = frame_command;
		r.payload_length = frame_length;
		return r;
	endfunction

	// Advance the tracker by one received byte; return 1 when it yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		bit cmd_ok;
		r = '0;
		cmd_ok = !(b < shadow_cfg.command_lowest || b > shadow_cfg.command_highest)
			|| b == COMMAND_ALWAYS_OK;
		case (frame_pos) inside
			POS_HUNT: begin
				hunt_from(b);
				return 1'b0;
			end
			POS_SYNC2: begin
				if (b == shadow_cfg.sync_second)
					frame_pos = POS_SYNC3;
				else
					hunt_from(b);
				return 1'b0;
			end
			POS_SYNC3: begin
				if (b == shadow_cfg.sync_third)
					frame_pos = POS_MODULE;
				else
					hunt_from(b);
				return 1'b0;
			end
			POS_MODULE: begin
				frame_module = b;
				frame_sum    = b;
				frame_pos    = POS_COMMAND;
				return 1'b0;
			end
			POS_COMMAND: begin
				// A rejected command byte gets a second chance as a sync byte.
				if (!cmd_ok) begin
					hunt_from(b);
					return 1'b0;
				end
				frame_command = b;
				frame_sum     = frame_sum + b;
				frame_pos     = POS_LEN_HI;
				return 1'b0;
			end
			POS_LEN_HI, POS_LEN_LO: begin
				if (frame_pos == POS_LEN_HI)
					frame_length = {b, 8'h00};
				else
					frame_length[7:0] = b;
				frame_sum = frame_sum + b;
				// Oversized length: report and consume this byte.
				if (frame_length > shadow_cfg.length_limit) begin
					r = frame_result(KIND_LEN_DROP, 8'h00);
					restart_hunt();
					return 1'b1;
				end
				frame_pos = frame_pos + 17'd1;
				return 1'b0;
			end
			default: begin
				if (frame_pos < POS_PAYLOAD + {1'b0, frame_length}) begin
					frame_sum = frame_sum + b;
					frame_pos = frame_pos + 17'd1;
					r = frame_result(KIND_PAYLOAD, b);
					return 1'b1;
				end
				// Checksum byte closes the frame, whatever the command.
				r = frame_result((frame_sum == b) ? KIND_ACCEPT : KIND_CSUM_ERR, 8'h00);
				restart_hunt();
				return 1'b1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending (kind)", int'(result_ch.kind), -1);
			return;
		end
		want = expected_results.pop_front();
		kind_count[int'(want.kind)]++;
		if (result_ch.kind != want.kind)
			report_mismatch("kind", int'(result_ch.kind), int'(want.kind));
		if (result_ch.payload_byte != want.payload_byte)
			report_mismatch("payload_byte", int'(result_ch.payload_byte),
				int'(want.payload_byte));
		if (result_ch.module_id != want.module_id)
			report_mismatch("module_id", int'(result_ch.module_id), int'(want.module_id));
		if (result_ch.command_code != want.command_code)
			report_mismatch("command_code", int'(result_ch.command_code),
				int'(want.command_code));
		if (result_ch.payload_length != want.payload_length)
			report_mismatch("payload_length", int'(result_ch.payload_length),
				int'(want.payload_length));
	endtask

	// Sample the result word on the edge, then pick next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_result();
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: end the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results still pending",
				STALL_LIMIT, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Offer one byte, idling first at random, and hold it until accepted.
	// Valid stays high afterwards so back-to-back bytes never toggle it.
	task automatic send_byte(input logic [7:0] b);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.rx_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
		if (deframe_byte(b, r))
			expected_results.insert(expected_results.size(), r);
	endtask

	task automatic send_bytes(input logic [7:0] stream [$]);
		foreach (stream[i])
			send_byte(stream[i]);
	endtask

	// Drop valid, wait for every pending result, then let the pipe drain
	// of bytes that produce nothing.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_SYNC_FIRST:      shadow_cfg.sync_first      = value[7:0];
			REG_SYNC_SECOND:     shadow_cfg.sync_second     = value[7:0];
			REG_SYNC_THIRD:      shadow_cfg.sync_third      = value[7:0];
			REG_COMMAND_LOWEST:  shadow_cfg.command_lowest  = value[7:0];
			REG_COMMAND_HIGHEST: shadow_cfg.command_highest = value[7:0];
			REG_LENGTH_LIMIT:    shadow_cfg.length_limit    = value;
			default: ;
		endcase
	endtask

	// Write all six registers while the block is idle.
	task automatic load_setting(input logic [7:0] s1, input logic [7:0] s2,
			input logic [7:0] s3, input logic [7:0] lo, input logic [7:0] hi,
			input logic [15:0] limit);
		settle();
		write_reg(REG_SYNC_FIRST, {8'h00, s1});
		write_reg(REG_SYNC_SECOND, {8'h00, s2});
		write_reg(REG_SYNC_THIRD, {8'h00, s3});
		write_reg(REG_COMMAND_LOWEST, {8'h00, lo});
		write_reg(REG_COMMAND_HIGHEST, {8'h00, hi});
		write_reg(REG_LENGTH_LIMIT, limit);
		cfg_ch.valid <= 1'b0;
		settings_done++;
	endtask

	// Six flavors of register setting, extremes among them.
	task automatic load_flavor(input int flavor);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'($urandom_range(255));
		hi = 8'($urandom_range(255));
		case (flavor)
			0: load_setting(8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 16'hffff);
			1: begin
				// Inverted command range: only command 1 gets through; limit zero.
				lo = 8'($urandom_range(255, 2));
				hi = 8'($urandom_range(lo - 1, 0));
				load_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), lo, hi, 16'h0000);
			end
			2: begin
				if (lo > hi)
					{lo, hi} = {hi, lo};
				load_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), lo, hi, 16'($urandom_range(40)));
			end
			3: load_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), lo, hi, 16'($urandom_range(16'hffff)));
			4: load_setting(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'h0100);
			default: load_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'h00, 8'h00, 16'($urandom_range(300, 1)));
		endcase
	endtask

	// Mostly well-formed frames for the current setting, with noise,
	// broken sync, rejected commands, oversized lengths, truncated payloads
	// and bad checksums mixed in.
	task automatic send_random_frame();
		logic [7:0]  module_b;
		logic [7:0]  command_b;
		logic [7:0]  csum;
		logic [7:0]  pay;
		logic [15:0] len;
		logic [15:0] cap;
		int          pick;
		int          cut;
		bit          inverted;
		pick     = int'($urandom_range(99));
		inverted = shadow_cfg.command_lowest > shadow_cfg.command_highest;
		if (pick < 8) begin
			repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
			return;
		end
		if (pick < 12) begin
			send_byte(shadow_cfg.sync_first);
			if ($urandom_range(1) != 0)
				send_byte(shadow_cfg.sync_second);
			send_byte(8'($urandom_range(255)));
			return;
		end
		send_byte(shadow_cfg.sync_first);
		send_byte(shadow_cfg.sync_second);
		send_byte(shadow_cfg.sync_third);

		module_b = 8'($urandom_range(255));
		pick     = int'($urandom_range(99));
		if (pick < 10 || (inverted && pick < 60))
			command_b = COMMAND_ALWAYS_OK;
		else if (pick < 18 || inverted)
			command_b = 8'($urandom_range(255));
		else
			command_b = 8'($urandom_range(shadow_cfg.command_highest,
				shadow_cfg.command_lowest));
		send_byte(module_b);
		send_byte(command_b);

		// Oversized length: half of them just one past the limit.
		pick = int'($urandom_range(99));
		if (pick < 12 && shadow_cfg.length_limit != 16'hffff) begin
			if (pick < 6)
				len = shadow_cfg.length_limit + 16'd1;
			else
				len = 16'($urandom_range(16'hffff, shadow_cfg.length_limit + 1));
			send_byte(len[15:8]);
			send_byte(len[7:0]);
			return;
		end

		// Keep payloads short; a few reach further.
		cap = (shadow_cfg.length_limit < 16'd12) ? shadow_cfg.length_limit : 16'd12;
		if (pick > 95)
			cap = (shadow_cfg.length_limit < 16'd200) ? shadow_cfg.length_limit : 16'd200;
		len  = 16'($urandom_range(cap, 0));
		csum = module_b + command_b + len[15:8] + len[7:0];
		send_byte(len[15:8]);
		send_byte(len[7:0]);

		// Truncate now and then: the next frame's bytes land in this payload.
		cut = ($urandom_range(99) < 4) ? int'($urandom_range(len)) : -1;
		for (int i = 0; i < len; i++) begin
			if (i == cut)
				return;
			pay  = 8'($urandom_range(255));
			csum = csum + pay;
			send_byte(pay);
		end
		if ($urandom_range(99) < 15)
			csum = csum ^ 8'($urandom_range(255, 1));
		send_byte(csum);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset values: zero sync word, full command range, limit 0x6000.
	// Command 0xff is at the top of the range; length 0x6000 passes the first
	// byte and 0x6001 drops on the second.
	task automatic test_reset_values();
		logic [7:0] stream [$];
		stream = '{8'h00, 8'h00, 8'h00, 8'h12, 8'hff, 8'h60, 8'h01};
		send_bytes(stream);
	endtask

	task automatic test_directed_frames();
		logic [7:0] stream [$];
		load_setting(8'hff, 8'h00, 8'h7e, 8'h10, 8'h20, 16'd4);
		// Repeated first sync byte restarts the hunt on itself; command 1 is
		// outside the range but always taken; zero length goes straight to the
		// checksum, 0x01 here, which matches.
		stream = '{8'hff, 8'hff, 8'h00, 8'h7e, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
		send_bytes(stream);
		// Command 0xff is rejected and retried as a first sync byte; the frame
		// that follows carries payload 0xff and a bad checksum (sum is 0xa0).
		stream = '{8'hff, 8'h00, 8'h7e, 8'h00, 8'hff, 8'h00, 8'h7e, 8'h80, 8'h20,
			8'h00, 8'h01, 8'hff, 8'h00};
		send_bytes(stream);
		// Length high byte alone already exceeds the limit.
		stream = '{8'hff, 8'h00, 8'h7e, 8'h05, 8'h10, 8'h01};
		send_bytes(stream);
	endtask

	// Random frames under two register settings for the given idle profile.
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int first_flavor);
		int goal;
		settle();
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int k = 0; k < 2; k++) begin
			load_flavor(first_flavor + k);
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal)
				send_random_frame();
		end
	endtask

	initial begin
		byte_ch.valid    = 1'b0;
		byte_ch.rx_byte  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = REG_SYNC_FIRST;
		cfg_ch.wdata     = '0;
		result_ch.ready  = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_frames();
		test_random_traffic(24, 87, 0);
		test_random_traffic(87, 24, 2);
		test_random_traffic(0, 0, 4);

		settle();
		$display("Covered %0d input bytes under %0d register settings and three idle profiles",
			bytes_sent, settings_done + 1);
		$display("Checked %0d payload bytes, %0d accepted, %0d checksum errors, %0d drops",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
